@@ hw/rtl/rrsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the round-robin session id allocator.
// Used by rrsa_ctrl, rrsa_dpath and the top level.
package rrsa_pkg;

  localparam int ID_W    = 12;
  localparam int WORD_W  = 32;
  localparam int BIT_AW  = 5;
  localparam int ROW_AW  = ID_W - BIT_AW;
  localparam int ROW_CNT = 1 << ROW_AW;
  localparam int POS_W   = ID_W + 1;

  localparam logic [1:0] KIND_ALLOC_SRV = 2'd0;
  localparam logic [1:0] KIND_ALLOC_CLI = 2'd1;
  localparam logic [1:0] KIND_FREE      = 2'd2;
  localparam logic [1:0] KIND_QUERY     = 2'd3;

  localparam logic [ID_W-1:0] SERVER_FIRST_DEF = 12'd1;
  localparam logic [ID_W-1:0] SERVER_END_DEF   = 12'd1024;
  localparam logic [ID_W-1:0] CLIENT_FIRST_DEF = 12'd1024;
  localparam logic [ID_W-1:0] CLIENT_END_DEF   = 12'd4095;

  typedef struct packed {
    logic accept;
    logic clear;
    logic read;
    logic eval;
    logic emit;
  } rrsa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic eval_done;
    logic out_free;
  } rrsa_sts_t;

endpackage

@@ hw/rtl/round_robin_session_id_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the round-robin session id allocator.
// Depends on rrsa_pkg, rrsa_ctrl and rrsa_dpath.
//
//   channel | direction | handshake          | payload
//   request | in        | in_valid/in_stall  | kind, id_in
//   result  | out       | out_valid/out_stall| id_out, flag
//
// After reset the 128-row bitmap is cleared, one row a cycle, with in_stall high.
// Free and query pass from accept through read, evaluate (free also writes back) and emit
// to the output register; a new request is accepted only once the previous one is emitted.
// Allocate reads and evaluates one 32-id bitmap row per pass; a full lap of a pool visits
// each row it spans, the cursor's row at most twice, so the read-evaluate loop sets the rate.
// A new request is taken while a result waits under out_stall; the next result waits for it.
module round_robin_session_id_allocator #(
  parameter logic [rrsa_pkg::ID_W-1:0] SERVER_FIRST = rrsa_pkg::SERVER_FIRST_DEF,
  parameter logic [rrsa_pkg::ID_W-1:0] SERVER_END   = rrsa_pkg::SERVER_END_DEF,
  parameter logic [rrsa_pkg::ID_W-1:0] CLIENT_FIRST = rrsa_pkg::CLIENT_FIRST_DEF,
  parameter logic [rrsa_pkg::ID_W-1:0] CLIENT_END   = rrsa_pkg::CLIENT_END_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                kind,
  input  logic [rrsa_pkg::ID_W-1:0] id_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rrsa_pkg::ID_W-1:0] id_out,
  output logic                      flag
);

  rrsa_pkg::rrsa_cmd_t cmd;
  rrsa_pkg::rrsa_sts_t sts;

  rrsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rrsa_dpath #(
    .SERVER_FIRST (SERVER_FIRST),
    .SERVER_END   (SERVER_END),
    .CLIENT_FIRST (CLIENT_FIRST),
    .CLIENT_END   (CLIENT_END)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .kind      (kind),
    .id_in     (id_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .id_out    (id_out),
    .flag      (flag)
  );

endmodule

@@ hw/rtl/rrsa_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the session id allocator.
// Depends on rrsa_pkg; drives rrsa_dpath through command and status structs.
module rrsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rrsa_pkg::rrsa_sts_t sts,
  output rrsa_pkg::rrsa_cmd_t cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        // keep scanning rows until the request settles
        state_next = sts.eval_done ? S_EMIT : S_READ;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

@@ hw/rtl/rrsa_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: used-id bitmap memory, pool cursors, row scanner and output register.
// Depends on rrsa_pkg; commanded by rrsa_ctrl.
module rrsa_dpath #(
  parameter logic [rrsa_pkg::ID_W-1:0] SERVER_FIRST = rrsa_pkg::SERVER_FIRST_DEF,
  parameter logic [rrsa_pkg::ID_W-1:0] SERVER_END   = rrsa_pkg::SERVER_END_DEF,
  parameter logic [rrsa_pkg::ID_W-1:0] CLIENT_FIRST = rrsa_pkg::CLIENT_FIRST_DEF,
  parameter logic [rrsa_pkg::ID_W-1:0] CLIENT_END   = rrsa_pkg::CLIENT_END_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rrsa_pkg::rrsa_cmd_t       cmd,
  output rrsa_pkg::rrsa_sts_t       sts,
  input  logic [1:0]                kind,
  input  logic [rrsa_pkg::ID_W-1:0] id_in,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rrsa_pkg::ID_W-1:0] id_out,
  output logic                      flag
);

  localparam int ID_W   = rrsa_pkg::ID_W;
  localparam int WORD_W = rrsa_pkg::WORD_W;
  localparam int BIT_AW = rrsa_pkg::BIT_AW;
  localparam int ROW_AW = rrsa_pkg::ROW_AW;
  localparam int POS_W  = rrsa_pkg::POS_W;
  localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(rrsa_pkg::ROW_CNT - 1);

  logic [WORD_W-1:0] mem [rrsa_pkg::ROW_CNT];

  logic [1:0]        kind_r;
  logic [ID_W-1:0]   id_r;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  limit;
  logic              phase;
  logic [ID_W-1:0]   srv_cur;
  logic [ID_W-1:0]   cli_cur;
  logic [ROW_AW-1:0] clr_row;
  logic [WORD_W-1:0] rdata;
  logic [ID_W-1:0]   res_id;
  logic              res_flag;

  logic              is_alloc;
  logic [ID_W-1:0]   cur;
  logic [POS_W-1:0]  pfirst;
  logic [POS_W-1:0]  pend;
  logic [ROW_AW-1:0] row;
  logic [POS_W-1:0]  base;
  logic [POS_W-1:0]  next_base;
  logic [WORD_W-1:0] win;
  logic [WORD_W-1:0] freem;
  logic              found;
  logic [BIT_AW-1:0] idx;
  logic [ID_W-1:0]   found_id;
  logic [POS_W-1:0]  nid;
  logic [ID_W-1:0]   cur_next;
  logic              wrap_ok;
  logic              row_end;
  logic              qbit;
  logic              we;
  logic [WORD_W-1:0] wdata;

  assign is_alloc  = !kind_r[1];
  assign cur       = kind_r[0] ? cli_cur : srv_cur;
  assign pfirst    = kind_r[0] ? {1'b0, CLIENT_FIRST} : {1'b0, SERVER_FIRST};
  assign pend      = kind_r[0] ? {1'b0, CLIENT_END} : {1'b0, SERVER_END};
  assign row       = pos[BIT_AW +: ROW_AW];
  assign base      = {1'b0, row, {BIT_AW{1'b0}}};
  assign next_base = base + POS_W'(WORD_W);

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      win[b] = ((base + POS_W'(b)) >= pos) && ((base + POS_W'(b)) < limit);
    end
  end

  assign freem = ~rdata & win;
  assign found = |freem;

  // lowest free bit in the window
  always_comb begin
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (freem[i]) begin
        idx = BIT_AW'(i);
      end
    end
  end

  assign found_id = {row, idx};
  assign nid      = {1'b0, found_id} + POS_W'(1);
  assign cur_next = (nid >= pend) ? pfirst[ID_W-1:0] : nid[ID_W-1:0];
  assign wrap_ok  = !phase && (pfirst < {1'b0, cur});
  assign row_end  = next_base >= limit;
  assign qbit     = rdata[id_r[BIT_AW-1:0]];

  assign sts.eval_done  = !is_alloc || found || (row_end && !wrap_ok);
  assign sts.clear_last = (clr_row == ROW_LAST);
  assign sts.out_free   = !out_valid || !out_stall;

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    case (kind_r)
      rrsa_pkg::KIND_FREE: begin
        we    = cmd.eval;
        wdata = rdata & ~(WORD_W'(1) << id_r[BIT_AW-1:0]);
      end
      rrsa_pkg::KIND_ALLOC_SRV, rrsa_pkg::KIND_ALLOC_CLI: begin
        we    = cmd.eval && found;
        wdata = rdata | (WORD_W'(1) << idx);
      end
      default: begin
        we    = 1'b0;
        wdata = rdata;
      end
    endcase
  end

  // bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mem[clr_row] <= '0;
    end else if (we) begin
      mem[row] <= wdata;
    end
    if (cmd.read) begin
      rdata <= mem[row];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row   <= '0;
      srv_cur   <= SERVER_FIRST;
      cli_cur   <= CLIENT_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear) begin
        clr_row <= clr_row + ROW_AW'(1);
      end
      if (cmd.eval && is_alloc && found) begin
        if (kind_r[0]) begin
          cli_cur <= cur_next;
        end else begin
          srv_cur <= cur_next;
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= kind;
      id_r   <= id_in;
      phase  <= 1'b0;
      if (kind[1]) begin
        pos <= {1'b0, id_in};
      end else begin
        pos <= {1'b0, (kind[0] ? cli_cur : srv_cur)};
      end
      limit <= kind[0] ? {1'b0, CLIENT_END} : {1'b0, SERVER_END};
    end else if (cmd.eval) begin
      if (sts.eval_done) begin
        case (kind_r)
          rrsa_pkg::KIND_FREE: begin
            res_id   <= id_r;
            res_flag <= 1'b0;
          end
          rrsa_pkg::KIND_QUERY: begin
            res_id   <= id_r;
            res_flag <= qbit;
          end
          default: begin
            res_id   <= found ? found_id : '0;
            res_flag <= found;
          end
        endcase
      end else if (row_end) begin
        // wrap: scan from the pool start up to the cursor
        phase <= 1'b1;
        pos   <= pfirst;
        limit <= {1'b0, cur};
      end else begin
        pos <= next_base;
      end
    end
    if (cmd.emit) begin
      id_out <= res_id;
      flag   <= res_flag;
    end
  end

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result not presented after emit");

  a_read_in_space: assert property (@(posedge clk) disable iff (rst)
    cmd.read |-> !pos[POS_W-1])
    else $error("scan position beyond id space");

  a_alloc_nonzero: assert property (@(posedge clk) disable iff (rst)
    (cmd.eval && is_alloc && found) |-> (found_id >= pfirst[ID_W-1:0]))
    else $error("allocated id below pool start");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for round_robin_session_id_allocator: directed rows, then a pool fill
// and a churn phase; typed directed rows are scored against their own results, the rest
// against an in-bench bitmap and cursor predictor. Depends on rrsa_pkg and the allocator RTL.
module testbench;

  localparam int ID_W        = rrsa_pkg::ID_W;
  localparam int CUR_W       = ID_W + 1;
  localparam int FILL_ITEMS  = 1100;
  localparam int CHURN_ITEMS = 350;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 16;
  localparam int DIR_ROWS    = 24;

  typedef struct packed {
    logic [1:0]      kind;
    logic [ID_W-1:0] id;
    logic            typed;
    logic [ID_W-1:0] id_out;
    logic            flag;
  } request_row_t;

  typedef struct packed {
    logic [ID_W-1:0] id_out;
    logic            flag;
  } id_result_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            in_valid = 1'b0;
  logic            in_stall;
  logic [1:0]      kind = rrsa_pkg::KIND_QUERY;
  logic [ID_W-1:0] id_in = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [ID_W-1:0] id_out;
  logic            flag;

  // bench copy of the allocator state
  logic            id_used [0:(1<<ID_W)-1];
  logic [ID_W-1:0] srv_cursor;
  logic [ID_W-1:0] cli_cursor;

  id_result_t      due_results [$];
  logic [ID_W-1:0] held_ids [$];
  int              err_cnt = 0;
  int              checked_cnt = 0;
  int              grant_cnt = 0;
  int              refuse_cnt = 0;
  int              free_cnt = 0;
  int              query_cnt = 0;
  int              burst_left = 0;

  request_row_t dir_rows [0:DIR_ROWS-1] = '{
    '{rrsa_pkg::KIND_QUERY,     12'd0,    1'b1, 12'd0,    1'b0},
    '{rrsa_pkg::KIND_QUERY,     12'hFFF,  1'b1, 12'hFFF,  1'b0},
    '{rrsa_pkg::KIND_ALLOC_SRV, 12'hFFF,  1'b1, 12'd1,    1'b1},
    '{rrsa_pkg::KIND_ALLOC_CLI, 12'd0,    1'b1, 12'd1024, 1'b1},
    '{rrsa_pkg::KIND_ALLOC_SRV, 12'hAAA,  1'b1, 12'd2,    1'b1},
    '{rrsa_pkg::KIND_QUERY,     12'd1,    1'b1, 12'd1,    1'b1},
    '{rrsa_pkg::KIND_FREE,      12'd1,    1'b1, 12'd1,    1'b0},
    '{rrsa_pkg::KIND_QUERY,     12'd1,    1'b1, 12'd1,    1'b0},
    '{rrsa_pkg::KIND_FREE,      12'd1,    1'b1, 12'd1,    1'b0},
    '{rrsa_pkg::KIND_ALLOC_SRV, 12'h555,  1'b1, 12'd3,    1'b1},
    '{rrsa_pkg::KIND_FREE,      12'd0,    1'b1, 12'd0,    1'b0},
    '{rrsa_pkg::KIND_FREE,      12'hFFF,  1'b1, 12'hFFF,  1'b0},
    '{rrsa_pkg::KIND_QUERY,     12'hAAA,  1'b1, 12'hAAA,  1'b0},
    '{rrsa_pkg::KIND_FREE,      12'h555,  1'b1, 12'h555,  1'b0},
    '{rrsa_pkg::KIND_QUERY,     12'd1024, 1'b1, 12'd1024, 1'b1},
    '{rrsa_pkg::KIND_ALLOC_CLI, 12'hFFF,  1'b1, 12'd1025, 1'b1},
    '{rrsa_pkg::KIND_FREE,      12'd1024, 1'b1, 12'd1024, 1'b0},
    '{rrsa_pkg::KIND_ALLOC_CLI, 12'd0,    1'b1, 12'd1026, 1'b1},
    '{rrsa_pkg::KIND_QUERY,     12'd1024, 1'b1, 12'd1024, 1'b0},
    '{rrsa_pkg::KIND_QUERY,     12'd1023, 1'b1, 12'd1023, 1'b0},
    '{rrsa_pkg::KIND_QUERY,     12'd4094, 1'b1, 12'd4094, 1'b0},
    '{rrsa_pkg::KIND_QUERY,     12'd2,    1'b0, 12'd0,    1'b0},
    '{rrsa_pkg::KIND_FREE,      12'd2,    1'b0, 12'd0,    1'b0},
    '{rrsa_pkg::KIND_ALLOC_SRV, 12'd0,    1'b0, 12'd0,    1'b0}
  };

  round_robin_session_id_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .id_in     (id_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .id_out    (id_out),
    .flag      (flag)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Scan a pool from its cursor, advancing and wrapping after every test.
  // Returns {granted, id}.
  function automatic logic [ID_W:0] take_id(inout logic [ID_W-1:0] cursor,
                                            input logic [ID_W-1:0] lo,
                                            input logic [ID_W-1:0] hi_excl);
    logic [ID_W:0]   tries;
    logic [ID_W-1:0] cand;
    logic [ID_W:0]   next;
    if (hi_excl <= lo) return '0;
    tries = {1'b0, hi_excl} - {1'b0, lo};
    for (int n = 0; n < tries; n++) begin
      cand = cursor;
      next = {1'b0, cand} + CUR_W'(1);
      if (next >= {1'b0, hi_excl}) next = {1'b0, lo};
      cursor = next[ID_W-1:0];
      if (!id_used[cand]) begin
        id_used[cand] = 1'b1;
        return {1'b1, cand};
      end
    end
    return '0;
  endfunction

  function automatic id_result_t predict_allocator(input logic [1:0] k,
                                                   input logic [ID_W-1:0] id);
    id_result_t  res;
    logic [ID_W:0] got;
    case (k)
      rrsa_pkg::KIND_ALLOC_SRV: begin
        got = take_id(srv_cursor, rrsa_pkg::SERVER_FIRST_DEF, rrsa_pkg::SERVER_END_DEF);
        res = '{got[ID_W] ? got[ID_W-1:0] : '0, got[ID_W]};
      end
      rrsa_pkg::KIND_ALLOC_CLI: begin
        got = take_id(cli_cursor, rrsa_pkg::CLIENT_FIRST_DEF, rrsa_pkg::CLIENT_END_DEF);
        res = '{got[ID_W] ? got[ID_W-1:0] : '0, got[ID_W]};
      end
      rrsa_pkg::KIND_FREE: begin
        id_used[id] = 1'b0;
        res = '{id, 1'b0};
      end
      default: res = '{id, id_used[id]};
    endcase
    return res;
  endfunction

  // Present one request, hold it until accepted, then record what it must return.
  task automatic send_request(input logic [1:0] k, input logic [ID_W-1:0] id,
                              input logic typed, input id_result_t typed_res);
    id_result_t res;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    kind     <= k;
    id_in    <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    res = predict_allocator(k, id);
    due_results.push_back(typed ? typed_res : res);
    case (k)
      rrsa_pkg::KIND_FREE:  free_cnt++;
      rrsa_pkg::KIND_QUERY: query_cnt++;
      default: begin
        if (res.flag) begin
          grant_cnt++;
          held_ids.push_back(res.id_out);
        end else begin
          refuse_cnt++;
        end
      end
    endcase
  endtask

  // Receiver: stretches of no stall, light, medium and heavy back-pressure.
  int          stall_mode = 0;
  int          mode_left = 0;
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Score each delivered result against the oldest pending one.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        $error("result with nothing pending: id_out=%0d flag=%0b", id_out, flag);
        err_cnt++;
      end else begin
        if (id_out !== due_results[0].id_out) begin
          $error("id_out: expected %0d, actual %0d", due_results[0].id_out, id_out);
          err_cnt++;
        end
        if (flag !== due_results[0].flag) begin
          $error("flag: expected %0b, actual %0b", due_results[0].flag, flag);
          err_cnt++;
        end
        void'(due_results.pop_front());
        checked_cnt++;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no request or result moved for %0d cycles, %0d results pending",
               IDLE_LIMIT, due_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int              roll;
    int              idx;
    logic [1:0]      k;
    logic [ID_W-1:0] rid;
    id_used = '{default: 1'b0};
    srv_cursor = rrsa_pkg::SERVER_FIRST_DEF;
    cli_cursor = rrsa_pkg::CLIENT_FIRST_DEF;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      send_request(dir_rows[r].kind, dir_rows[r].id, dir_rows[r].typed,
                   '{dir_rows[r].id_out, dir_rows[r].flag});
    end

    // Fill phase drives the server pool to exhaustion; churn then frees and reuses ids.
    for (int i = 0; i < FILL_ITEMS + CHURN_ITEMS; i++) begin
      roll = $urandom_range(0, 99);
      rid  = ID_W'($urandom_range(0, (1 << ID_W) - 1));
      if (i < FILL_ITEMS)
        k = (roll < 97) ? rrsa_pkg::KIND_ALLOC_SRV : (roll < 98) ? rrsa_pkg::KIND_ALLOC_CLI :
            (roll < 99) ? rrsa_pkg::KIND_FREE : rrsa_pkg::KIND_QUERY;
      else
        k = (roll < 35) ? rrsa_pkg::KIND_ALLOC_SRV : (roll < 45) ? rrsa_pkg::KIND_ALLOC_CLI :
            (roll < 75) ? rrsa_pkg::KIND_FREE : rrsa_pkg::KIND_QUERY;
      if ((k == rrsa_pkg::KIND_FREE || k == rrsa_pkg::KIND_QUERY) && held_ids.size() > 0 &&
          $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, held_ids.size() - 1);
        rid = held_ids[idx];
        if (k == rrsa_pkg::KIND_FREE) held_ids.delete(idx);
      end
      send_request(k, rid, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Sent %0d requests: %0d ids granted, %0d refused on a full pool,",
             grant_cnt + refuse_cnt + free_cnt + query_cnt, grant_cnt, refuse_cnt);
    $display("%0d frees, %0d queries; checked %0d results, %0d mismatches",
             free_cnt, query_cnt, checked_cnt, err_cnt);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rrsa_pkg.sv
hw/rtl/rrsa_ctrl.sv
hw/rtl/rrsa_dpath.sv
hw/rtl/round_robin_session_id_allocator.sv
test/testbench.sv
